>>> hdl/etm_pkg.sv
// ----------------------------------------------------------------------------
// etm_pkg
// Shared types, constants and arithmetic helpers of the Euler transform unit.
// ----------------------------------------------------------------------------
package etm_pkg;

    localparam int FRAC_BITS = 16;

    // CORDIC datapath: Q2.30 sine and cosine with headroom.
    localparam int CW          = 34;
    localparam int ZW          = 34;
    localparam int STEPS       = 16;
    localparam int CORDIC_GAIN = 652032874;

    localparam logic [31:0] ATAN [STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861
    };

    // Reciprocal dividend: 2^(2*FRAC_BITS) plus half of a 31-bit magnitude.
    localparam int DW = ((2 * FRAC_BITS >= 31) ? 2 * FRAC_BITS : 31) + 1;
    localparam logic [DW-1:0] RCP_NUM = DW'(1) << (2 * FRAC_BITS);

    // Stage counts, taking the input register as stage zero.
    localparam int ROT_LAT  = STEPS + 3;
    localparam int RCP_LAT  = DW + 2;
    localparam int PIPE_LAT = (ROT_LAT > RCP_LAT) ? ROT_LAT : RCP_LAT;

    typedef logic signed [CW-1:0] t_rent;
    typedef t_rent [2:0][2:0]     t_rot;   // [column][row]
    typedef logic signed [31:0]   t_word;
    typedef t_word [2:0]          t_fac;

    typedef struct packed {
        logic        command;
        logic [15:0] angle_x;
        logic [15:0] angle_y;
        logic [15:0] angle_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
    } t_in;

    typedef struct packed {
        logic [1:0]         column;
        logic signed [31:0] elem0;
        logic signed [31:0] elem1;
        logic signed [31:0] elem2;
        logic signed [31:0] elem3;
        logic               last;
        logic               zero_scale;
    } t_out;

    typedef struct packed {
        logic  normal;
        logic  zflag;
        t_word shift_x;
        t_word shift_y;
        t_word shift_z;
    } t_ctl;

    // Q2.30 product rounded back to Q2.30 (floor after adding one half).
    function automatic t_rent mul30(input t_rent a, input t_rent b);
        logic signed [2*CW-1:0] p;
        p = a * b;
        p = p + $signed({{(2*CW-30){1'b0}}, 1'b1, 29'd0});
        return t_rent'(p >>> 30);
    endfunction

endpackage

>>> hdl/etm_cordic.sv
// ----------------------------------------------------------------------------
// etm_cordic
// Pipelined rotation CORDIC, one iteration per stage, with quadrant fold.
// ----------------------------------------------------------------------------
module etm_cordic (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [15:0]          i_angle,
    output etm_pkg::t_rent       o_cos,
    output etm_pkg::t_rent       o_sin
);

    etm_pkg::t_rent           w_x [0:etm_pkg::STEPS];
    etm_pkg::t_rent           w_y [0:etm_pkg::STEPS];
    logic signed [etm_pkg::ZW-1:0] w_z [0:etm_pkg::STEPS];
    logic [1:0]               w_q [0:etm_pkg::STEPS];

    etm_pkg::t_rent r_cos;
    etm_pkg::t_rent r_sin;

    assign w_x[0] = etm_pkg::t_rent'(etm_pkg::CORDIC_GAIN);
    assign w_y[0] = '0;
    assign w_z[0] = $signed(etm_pkg::ZW'({i_angle[13:0], 16'd0}));
    assign w_q[0] = i_angle[15:14];

    for (genvar k = 0; k < etm_pkg::STEPS; k++) begin : g_step
        etm_pkg::t_rent                r_x;
        etm_pkg::t_rent                r_y;
        logic signed [etm_pkg::ZW-1:0] r_z;
        logic [1:0]                    r_q;
        etm_pkg::t_rent                n_x;
        etm_pkg::t_rent                n_y;
        logic signed [etm_pkg::ZW-1:0] n_z;
        logic signed [etm_pkg::ZW-1:0] w_a;

        assign w_a = $signed(etm_pkg::ZW'(etm_pkg::ATAN[k]));

        always_comb begin
            if (!w_z[k][etm_pkg::ZW-1]) begin
                n_x = w_x[k] - (w_y[k] >>> k);
                n_y = w_y[k] + (w_x[k] >>> k);
                n_z = w_z[k] - w_a;
            end else begin
                n_x = w_x[k] + (w_y[k] >>> k);
                n_y = w_y[k] - (w_x[k] >>> k);
                n_z = w_z[k] + w_a;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
                r_q <= w_q[k];
            end
        end

        assign w_x[k+1] = r_x;
        assign w_y[k+1] = r_y;
        assign w_z[k+1] = r_z;
        assign w_q[k+1] = r_q;
    end

    // Quadrant rotates the first-quadrant result by a multiple of 90 degrees.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_q[etm_pkg::STEPS][0]) begin
                r_cos <= w_q[etm_pkg::STEPS][1] ? w_y[etm_pkg::STEPS] : -w_y[etm_pkg::STEPS];
                r_sin <= w_q[etm_pkg::STEPS][1] ? -w_x[etm_pkg::STEPS] : w_x[etm_pkg::STEPS];
            end else begin
                r_cos <= w_q[etm_pkg::STEPS][1] ? -w_x[etm_pkg::STEPS] : w_x[etm_pkg::STEPS];
                r_sin <= w_q[etm_pkg::STEPS][1] ? -w_y[etm_pkg::STEPS] : w_y[etm_pkg::STEPS];
            end
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

>>> hdl/etm_recip.sv
// ----------------------------------------------------------------------------
// etm_recip
// Pipelined restoring divider giving the rounded, saturated reciprocal, or the
// scale itself when the item asks for the model matrix.
// ----------------------------------------------------------------------------
module etm_recip (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic          i_normal,
    input  etm_pkg::t_word i_scale,
    output etm_pkg::t_word o_recip
);

    logic [31:0]             w_rem  [0:etm_pkg::DW];
    logic [etm_pkg::DW-1:0]  w_acc  [0:etm_pkg::DW];
    logic [31:0]             w_mag  [0:etm_pkg::DW];
    logic                    w_neg  [0:etm_pkg::DW];
    logic                    w_zero [0:etm_pkg::DW];
    logic                    w_nrm  [0:etm_pkg::DW];

    logic [31:0]            r_mag;
    logic [etm_pkg::DW-1:0] r_acc;
    logic                   r_neg;
    logic                   r_zero;
    logic                   r_nrm;
    logic [31:0]            n_mag;
    etm_pkg::t_word         r_recip;
    logic [etm_pkg::DW-1:0] w_q;

    assign n_mag = i_scale[31] ? 32'(-i_scale) : 32'(i_scale);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag  <= n_mag;
            r_acc  <= etm_pkg::RCP_NUM + etm_pkg::DW'(n_mag >> 1);
            r_neg  <= i_scale[31];
            r_zero <= (i_scale == '0);
            r_nrm  <= i_normal;
        end
    end

    assign w_rem[0]  = '0;
    assign w_acc[0]  = r_acc;
    assign w_mag[0]  = r_mag;
    assign w_neg[0]  = r_neg;
    assign w_zero[0] = r_zero;
    assign w_nrm[0]  = r_nrm;

    // The quotient bits shift into the dividend register as it empties.
    for (genvar k = 0; k < etm_pkg::DW; k++) begin : g_div
        logic [31:0]            r_rem;
        logic [etm_pkg::DW-1:0] r_a;
        logic [31:0]            r_m;
        logic                   r_n;
        logic                   r_z;
        logic                   r_p;
        logic [32:0]            w_t;
        logic                   w_ge;

        assign w_t  = {w_rem[k], w_acc[k][etm_pkg::DW-1]};
        assign w_ge = (w_t >= {1'b0, w_mag[k]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= w_ge ? 32'(w_t - {1'b0, w_mag[k]}) : w_t[31:0];
                r_a   <= {w_acc[k][etm_pkg::DW-2:0], w_ge};
                r_m   <= w_mag[k];
                r_n   <= w_neg[k];
                r_z   <= w_zero[k];
                r_p   <= w_nrm[k];
            end
        end

        assign w_rem[k+1]  = r_rem;
        assign w_acc[k+1]  = r_a;
        assign w_mag[k+1]  = r_m;
        assign w_neg[k+1]  = r_n;
        assign w_zero[k+1] = r_z;
        assign w_nrm[k+1]  = r_p;
    end

    assign w_q = w_acc[etm_pkg::DW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!w_nrm[etm_pkg::DW]) begin
                // The model matrix scales by the factor itself.
                r_recip <= w_neg[etm_pkg::DW] ? $signed(32'(-w_mag[etm_pkg::DW]))
                                              : $signed(w_mag[etm_pkg::DW]);
            end else if (w_zero[etm_pkg::DW]) begin
                r_recip <= 32'sh7FFF_FFFF;
            end else if (!w_neg[etm_pkg::DW]) begin
                r_recip <= (w_q > etm_pkg::DW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                               : $signed(w_q[31:0]);
            end else begin
                r_recip <= (w_q > etm_pkg::DW'(32'h8000_0000)) ? $signed(32'h8000_0000)
                                                               : $signed(32'(-w_q[31:0]));
            end
        end
    end

    assign o_recip = r_recip;

endmodule

>>> hdl/etm_rotate.sv
// ----------------------------------------------------------------------------
// etm_rotate
// Two-stage product tree forming the Y-X-Z rotation matrix.
// ----------------------------------------------------------------------------
module etm_rotate (
    input  logic           i_clk,
    input  logic           i_en,
    input  etm_pkg::t_rent i_c1,
    input  etm_pkg::t_rent i_s1,
    input  etm_pkg::t_rent i_c2,
    input  etm_pkg::t_rent i_s2,
    input  etm_pkg::t_rent i_c3,
    input  etm_pkg::t_rent i_s3,
    output etm_pkg::t_rot  o_rot
);

    etm_pkg::t_rent r_c1c3, r_s1s2, r_c2s3, r_c1s2, r_c3s1;
    etm_pkg::t_rent r_c1s3, r_c2c3, r_s1s3, r_c2s1, r_c1c2;
    etm_pkg::t_rent r_s2, r_s3;
    etm_pkg::t_rot  r_rot;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1c3 <= etm_pkg::mul30(i_c1, i_c3);
            r_s1s2 <= etm_pkg::mul30(i_s1, i_s2);
            r_c2s3 <= etm_pkg::mul30(i_c2, i_s3);
            r_c1s2 <= etm_pkg::mul30(i_c1, i_s2);
            r_c3s1 <= etm_pkg::mul30(i_c3, i_s1);
            r_c1s3 <= etm_pkg::mul30(i_c1, i_s3);
            r_c2c3 <= etm_pkg::mul30(i_c2, i_c3);
            r_s1s3 <= etm_pkg::mul30(i_s1, i_s3);
            r_c2s1 <= etm_pkg::mul30(i_c2, i_s1);
            r_c1c2 <= etm_pkg::mul30(i_c1, i_c2);
            r_s2   <= i_s2;
            r_s3   <= i_s3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot[0][0] <= r_c1c3 + etm_pkg::mul30(r_s1s2, r_s3);
            r_rot[0][1] <= r_c2s3;
            r_rot[0][2] <= etm_pkg::mul30(r_c1s2, r_s3) - r_c3s1;
            r_rot[1][0] <= etm_pkg::mul30(r_c3s1, r_s2) - r_c1s3;
            r_rot[1][1] <= r_c2c3;
            r_rot[1][2] <= etm_pkg::mul30(r_c1c3, r_s2) + r_s1s3;
            r_rot[2][0] <= r_c2s1;
            r_rot[2][1] <= -r_s2;
            r_rot[2][2] <= r_c1c2;
        end
    end

    assign o_rot = r_rot;

endmodule

>>> hdl/etm_column.sv
// ----------------------------------------------------------------------------
// etm_column
// Holds one finished matrix; sends one scaled column per unstalled cycle.
// ----------------------------------------------------------------------------
module etm_column (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  etm_pkg::t_rot  i_rot,
    input  etm_pkg::t_fac  i_fac,
    input  etm_pkg::t_ctl  i_ctl,
    output logic           o_ready,
    output logic           o_valid,
    output etm_pkg::t_out  o_data,
    input  logic           i_stall
);

    logic          r_have;
    logic [1:0]    r_col;
    etm_pkg::t_rot r_rot;
    etm_pkg::t_fac r_fac;
    etm_pkg::t_ctl r_ctl;
    logic          r_oval;
    etm_pkg::t_out r_out;

    logic          w_free;
    logic          w_fire;
    logic          w_last;
    logic [1:0]    w_idx;
    etm_pkg::t_out n_out;

    function automatic etm_pkg::t_word scale_elem(input etm_pkg::t_rent a,
                                                   input etm_pkg::t_word b);
        logic signed [etm_pkg::CW+31:0] p;
        logic signed [etm_pkg::CW+1:0]  s;
        p = a * b;
        p = p + $signed({{(etm_pkg::CW+2){1'b0}}, 1'b1, 29'd0});
        s = (etm_pkg::CW+2)'(p >>> 30);
        if (s > $signed((etm_pkg::CW+2)'(32'h7FFF_FFFF))) begin
            return 32'sh7FFF_FFFF;
        end else if (s < $signed({{(etm_pkg::CW-30){1'b1}}, 32'h8000_0000})) begin
            return $signed(32'h8000_0000);
        end
        return etm_pkg::t_word'(s);
    endfunction

    assign w_free = !r_oval || !i_stall;
    assign w_fire = r_have && w_free;
    assign w_last = r_ctl.normal ? (r_col == 2'd2) : (r_col == 2'd3);
    assign w_idx  = (r_col == 2'd3) ? 2'd0 : r_col;
    assign o_ready = !r_have || (w_fire && w_last);

    always_comb begin
        n_out.column     = r_col;
        n_out.last       = w_last;
        n_out.zero_scale = r_ctl.normal && r_ctl.zflag;
        if (r_col == 2'd3) begin
            n_out.elem0 = r_ctl.shift_x;
            n_out.elem1 = r_ctl.shift_y;
            n_out.elem2 = r_ctl.shift_z;
            n_out.elem3 = $signed(32'(1) << etm_pkg::FRAC_BITS);
        end else begin
            n_out.elem0 = scale_elem(r_rot[w_idx][0], $signed(r_fac[w_idx]));
            n_out.elem1 = scale_elem(r_rot[w_idx][1], $signed(r_fac[w_idx]));
            n_out.elem2 = scale_elem(r_rot[w_idx][2], $signed(r_fac[w_idx]));
            n_out.elem3 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_col  <= 2'd0;
            r_oval <= 1'b0;
        end else begin
            if (w_free) begin
                r_oval <= w_fire;
            end
            if (i_load) begin
                r_have <= 1'b1;
                r_col  <= 2'd0;
            end else if (w_fire) begin
                if (w_last) begin
                    r_have <= 1'b0;
                end else begin
                    r_col <= r_col + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rot <= i_rot;
            r_fac <= i_fac;
            r_ctl <= i_ctl;
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_oval;
    assign o_data  = r_out;

    // A column that is not the last one and is not stalled is followed at once by the next.
    a_next_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_data.last
        |=> o_valid && (o_data.column == $past(o_data.column) + 2'd1))
        else $error("column sequence broken");

    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.last |-> (o_data.column == 2'd2 || o_data.column == 2'd3))
        else $error("last flag on wrong column");

    a_flag_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.zero_scale |-> (o_data.elem3 == '0) && (o_data.column != 2'd3))
        else $error("zero scale flag on a model matrix");

endmodule

>>> hdl/euler_transform_matrix_core.sv
// ----------------------------------------------------------------------------
// euler_transform_matrix_core
// Euler angle (Y, X, Z) model and normal matrix generator.
// ----------------------------------------------------------------------------
// An accepted item runs through a fixed pipeline of PIPE_LAT stages (35 at
// 16 fraction bits), whose length is set by the bit-per-stage reciprocal
// divider; the sine and cosine CORDIC and the rotation products run beside
// it. The finished matrix then leaves one column per cycle from the output
// register while the output is not stalled; a model matrix has four columns
// and a normal matrix three. The input is taken again as soon as the last
// column is being sent; the whole pipeline holds while a finished matrix
// waits at its end and the previous one is still being sent.
module euler_transform_matrix_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  etm_pkg::t_in  i_in_data,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output etm_pkg::t_out o_out_data,
    input  logic          i_out_stall
);

    localparam int L   = etm_pkg::PIPE_LAT;
    localparam int DRT = etm_pkg::PIPE_LAT - etm_pkg::ROT_LAT;
    localparam int DRC = etm_pkg::PIPE_LAT - etm_pkg::RCP_LAT;

    logic          r_vld [0:L];
    etm_pkg::t_ctl r_ctl [0:L];
    etm_pkg::t_in  r_in;

    logic           w_en;
    logic           w_ready;
    etm_pkg::t_rent w_c1, w_s1, w_c2, w_s2, w_c3, w_s3;
    etm_pkg::t_rot  w_rot [0:DRT];
    etm_pkg::t_fac  w_fac [0:DRC];

    assign w_en       = !r_vld[L] || w_ready;
    assign o_in_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= L; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k <= L; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in             <= i_in_data;
            r_ctl[0].normal  <= i_in_data.command;
            r_ctl[0].zflag   <= (i_in_data.scale_x == '0) || (i_in_data.scale_y == '0)
                                || (i_in_data.scale_z == '0);
            r_ctl[0].shift_x <= i_in_data.shift_x;
            r_ctl[0].shift_y <= i_in_data.shift_y;
            r_ctl[0].shift_z <= i_in_data.shift_z;
            for (int k = 1; k <= L; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    etm_cordic u_cordic_y (.i_clk(i_clk), .i_en(w_en), .i_angle(r_in.angle_y),
                           .o_cos(w_c1), .o_sin(w_s1));
    etm_cordic u_cordic_x (.i_clk(i_clk), .i_en(w_en), .i_angle(r_in.angle_x),
                           .o_cos(w_c2), .o_sin(w_s2));
    etm_cordic u_cordic_z (.i_clk(i_clk), .i_en(w_en), .i_angle(r_in.angle_z),
                           .o_cos(w_c3), .o_sin(w_s3));

    etm_rotate u_rotate (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_c1  (w_c1),
        .i_s1  (w_s1),
        .i_c2  (w_c2),
        .i_s2  (w_s2),
        .i_c3  (w_c3),
        .i_s3  (w_s3),
        .o_rot (w_rot[0])
    );

    etm_recip u_recip_x (.i_clk(i_clk), .i_en(w_en), .i_normal(r_in.command),
                         .i_scale(r_in.scale_x), .o_recip(w_fac[0][0]));
    etm_recip u_recip_y (.i_clk(i_clk), .i_en(w_en), .i_normal(r_in.command),
                         .i_scale(r_in.scale_y), .o_recip(w_fac[0][1]));
    etm_recip u_recip_z (.i_clk(i_clk), .i_en(w_en), .i_normal(r_in.command),
                         .i_scale(r_in.scale_z), .o_recip(w_fac[0][2]));

    // Align the shorter path with the end of the pipeline.
    for (genvar k = 0; k < DRT; k++) begin : g_rot_dly
        etm_pkg::t_rot r_rot;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rot <= w_rot[k];
            end
        end
        assign w_rot[k+1] = r_rot;
    end

    for (genvar k = 0; k < DRC; k++) begin : g_fac_dly
        etm_pkg::t_fac r_fac;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_fac <= w_fac[k];
            end
        end
        assign w_fac[k+1] = r_fac;
    end

    etm_column u_column (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_en && r_vld[L]),
        .i_rot   (w_rot[DRT]),
        .i_fac   (w_fac[DRC]),
        .i_ctl   (r_ctl[L]),
        .o_ready (w_ready),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

    // The pipeline only holds while a finished matrix waits at its end.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_vld[L])
        else $error("input stalled with an empty pipeline end");

endmodule
